>>> rtl/bmh_pkg.sv
// Package for the binary min-heap core: sizes, command and status codes,
// and the command and status types that pass between controller and datapath.
// No dependencies.
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int STAT_W   = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [3:0] t_dp_op;

    localparam t_dp_op DP_NOP       = 4'd0;
    localparam t_dp_op DP_ACCEPT    = 4'd1;
    localparam t_dp_op DP_RD_PARENT = 4'd2;
    localparam t_dp_op DP_UP_MOVE   = 4'd3;
    localparam t_dp_op DP_DEL_START = 4'd4;
    localparam t_dp_op DP_DEL_LOAD  = 4'd5;
    localparam t_dp_op DP_RD_KIDS   = 4'd6;
    localparam t_dp_op DP_DN_MOVE   = 4'd7;
    localparam t_dp_op DP_PLACE     = 4'd8;
    localparam t_dp_op DP_OUTPUT    = 4'd9;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_delete;   // incoming beat asks for a delete
        logic in_reject;   // incoming beat hits a full or empty heap
        logic is_delete;   // command held for the current item
        logic pos_zero;    // hole sits at the root
        logic up_less;     // held key is below the parent just read
        logic leaf;        // hole has no child inside the heap
        logic dn_less;     // smaller child is below the held key
        logic count_zero;  // heap holds no entry
        logic out_free;    // output register can take a result
    } t_dp_stat;

endpackage

>>> rtl/bmh_datapath.sv
// Datapath of the binary min-heap core: heap memory, hole position, held key,
// entry count, cached root and the result register. Depends on bmh_pkg.
module bmh_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmh_pkg::t_dp_cmd                    i_cmd,
    output bmh_pkg::t_dp_stat                   o_stat,
    input  logic                                i_command,
    input  logic signed [bmh_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bmh_pkg::VALUE_W-1:0]  o_removed_value,
    output logic signed [bmh_pkg::VALUE_W-1:0]  o_top_value,
    output logic [bmh_pkg::CNT_W-1:0]           o_count_after,
    output logic [bmh_pkg::STAT_W-1:0]          o_status
);
    import bmh_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_a, r_rd_b;

    logic [ADDR_W-1:0]         r_pos, n_pos;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [VALUE_W-1:0] r_top;
    logic signed [VALUE_W-1:0] r_removed, n_removed;
    logic [STAT_W-1:0]         r_status, n_status;
    logic                      r_cmd, n_cmd;

    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_removed, r_out_top;
    logic [CNT_W-1:0]          r_out_count;
    logic [STAT_W-1:0]         r_out_status;

    logic [ADDR_W-1:0]         parent;
    logic [CNT_W:0]            first_child, second_child;
    logic                      has_right, pick_right;
    logic signed [VALUE_W-1:0] pick_val;
    logic [ADDR_W-1:0]         pick_pos;
    logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b, wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      wr_en;
    logic                      full;

    assign full         = (r_count == CNT_W'(CAPACITY));
    assign parent       = (r_pos - ADDR_W'(1)) >> 1;
    assign first_child  = {1'b0, r_pos, 1'b1};
    assign second_child = first_child + (CNT_W+1)'(1);
    assign has_right    = (second_child < {1'b0, r_count});
    assign pick_right   = has_right && (r_rd_b < r_rd_a);
    assign pick_val     = pick_right ? r_rd_b : r_rd_a;
    assign pick_pos     = pick_right ? second_child[ADDR_W-1:0] : first_child[ADDR_W-1:0];

    always_comb begin
        rd_addr_a = parent;
        rd_addr_b = second_child[ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_val;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_removed = r_removed;
        n_status  = r_status;
        n_cmd     = r_cmd;
        case (i_cmd.op)
            DP_ACCEPT: begin
                n_cmd     = i_command;
                n_val     = i_value;
                n_pos     = r_count[ADDR_W-1:0];
                n_removed = '0;
                if (i_command == CMD_INSERT && full) begin
                    n_status = ST_FULL;
                end else if (i_command == CMD_DELETE && r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_OK;
                end
            end
            DP_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_a;
                n_pos   = parent;
            end
            DP_DEL_START: begin
                n_count   = r_count - CNT_W'(1);
                n_removed = r_top;
                rd_addr_a = n_count[ADDR_W-1:0];
            end
            DP_DEL_LOAD: begin
                n_val = r_rd_a;
                n_pos = '0;
            end
            DP_RD_KIDS: begin
                rd_addr_a = first_child[ADDR_W-1:0];
            end
            DP_DN_MOVE: begin
                wr_en   = 1'b1;
                wr_data = pick_val;
                n_pos   = pick_pos;
            end
            DP_PLACE: begin
                wr_en = 1'b1;
                if (r_cmd == CMD_INSERT) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_cmd     <= n_cmd;
        if (wr_en && wr_addr == '0) begin
            r_top <= wr_data;
        end
        if (i_cmd.op == DP_OUTPUT) begin
            r_out_removed <= r_removed;
            r_out_top     <= (r_count == '0) ? '0 : r_top;
            r_out_count   <= r_count;
            r_out_status  <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.op == DP_OUTPUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.in_delete  = (i_command == CMD_DELETE);
        o_stat.in_reject  = (i_command == CMD_INSERT) ? full : (r_count == '0);
        o_stat.is_delete  = (r_cmd == CMD_DELETE);
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.up_less    = (r_val < r_rd_a);
        o_stat.leaf       = (first_child >= {1'b0, r_count});
        o_stat.dn_less    = (pick_val < r_val);
        o_stat.count_zero = (r_count == '0);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_top_value     = r_out_top;
    assign o_count_after   = r_out_count;
    assign o_status        = r_out_status;

endmodule

>>> rtl/bmh_ctrl.sv
// Controller of the binary min-heap core: sequences sift-up and sift-down
// through the datapath one level at a time. Depends on bmh_pkg.
module bmh_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bmh_pkg::t_dp_stat  i_stat,
    output bmh_pkg::t_dp_cmd   o_cmd
);
    import bmh_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_CHECK = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_DEL_RD   = 4'd3;
    localparam logic [3:0] S_DEL_LOAD = 4'd4;
    localparam logic [3:0] S_DN_CHECK = 4'd5;
    localparam logic [3:0] S_DN_CMP   = 4'd6;
    localparam logic [3:0] S_PLACE    = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = DP_ACCEPT;
                    if (i_stat.in_reject) begin
                        n_state = S_FINISH;
                    end else if (i_stat.in_delete) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_state = S_UP_CHECK;
                    end
                end
            end
            S_UP_CHECK: begin
                if (i_stat.pos_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.op = DP_RD_PARENT;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_less) begin
                    o_cmd.op = DP_UP_MOVE;
                    n_state  = S_UP_CHECK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DEL_RD: begin
                o_cmd.op = DP_DEL_START;
                n_state  = S_DEL_LOAD;
            end
            S_DEL_LOAD: begin
                if (i_stat.count_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = DP_DEL_LOAD;
                    n_state  = S_DN_CHECK;
                end
            end
            S_DN_CHECK: begin
                if (i_stat.leaf) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.op = DP_RD_KIDS;
                    n_state  = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_less) begin
                    o_cmd.op = DP_DN_MOVE;
                    n_state  = S_DN_CHECK;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.op = DP_PLACE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_OUTPUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The input is held off while reset is asserted.
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

endmodule

>>> rtl/binary_min_heap_core.sv
// Top level of the binary min-heap priority queue: joins controller and datapath.
// Depends on bmh_pkg, bmh_ctrl and bmh_datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_command, i_value
//   out      output     o_out_valid / i_out_ready o_removed_value, o_top_value,
//                                                 o_count_after, o_status
//
// One command is worked on at a time. An insert is accepted, climbs level by
// level and is placed, then its result is handed off; a delete is accepted,
// reads and loads the last entry into the hole at the root, sinks it level by
// level, places it and hands off the result. The walk is set by the heap
// memory: each level reads in a check state, then compares and writes in a
// compare state. A rejected command (delete on empty, insert on full) goes
// straight to the hand-off, and deleting the only entry skips the sift-down. A
// result register that is still full adds its wait to the last cycle.
// Reset clears the entry count and the output register; memory needs no clearing.
// The input is not ready while reset is held.
// A result waiting in the output register does not stop the next beat from
// being accepted; only the final hand-off of that next result waits for it.
module binary_min_heap_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic signed [bmh_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bmh_pkg::VALUE_W-1:0]  o_removed_value,
    output logic signed [bmh_pkg::VALUE_W-1:0]  o_top_value,
    output logic [bmh_pkg::CNT_W-1:0]           o_count_after,
    output logic [bmh_pkg::STAT_W-1:0]          o_status
);
    import bmh_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller walks the heap level by level.
    bmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the heap memory, the hole position and the result.
    bmh_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_value (o_removed_value),
        .o_top_value     (o_top_value),
        .o_count_after   (o_count_after),
        .o_status        (o_status)
    );

endmodule
